/* hdl/sensor_frame_deframer_macros.svh */
// ---------------------------------------------------------------------------
// sensor_frame_deframer assertion macros
// shared concurrent assertion forms for the deframer
// ---------------------------------------------------------------------------
`ifndef SENSOR_FRAME_DEFRAMER_MACROS_SVH
`define SENSOR_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/sfd_pkg.sv */
// ---------------------------------------------------------------------------
// sfd_pkg
// types and constants shared by the sensor frame deframer modules
// ---------------------------------------------------------------------------
package sfd_pkg;

   // payload bytes kept per frame (fields use bytes zero to nine)
   localparam int KEPT_BYTES = 10;
   localparam int BYTE_IDX_W = $clog2(KEPT_BYTES);
   localparam int PAYLOAD_W  = KEPT_BYTES * 8;

   localparam logic [7:0] SYNC_BYTE  = 8'h5A;
   localparam logic [7:0] TYPE_LIGHT = 8'h15;
   localparam logic [7:0] TYPE_ENV   = 8'h45;

   localparam logic [31:0] PRESS_LOW_RESET  = 32'd80000;
   localparam logic [31:0] PRESS_HIGH_RESET = 32'd120000;
   localparam logic [31:0] PRESS_FALL_RESET = 32'd101325;

   // frame queue between parser and decoder
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_LOW_LIMIT  = 2'd0,
      REG_HIGH_LIMIT = 2'd1,
      REG_FALLBACK   = 2'd2
   } reg_idx_type;

   typedef enum logic [1:0] {
      KIND_LIGHT   = 2'd0,
      KIND_ENV     = 2'd1,
      KIND_UNKNOWN = 2'd2
   } frame_kind_type;

   typedef enum logic [5:0] {
      PH_SYNC1 = 6'b000001,
      PH_SYNC2 = 6'b000010,
      PH_TYPE  = 6'b000100,
      PH_LEN   = 6'b001000,
      PH_DATA  = 6'b010000,
      PH_CSUM  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0]           raw_type;
      logic [7:0]           frame_length;
      logic [PAYLOAD_W-1:0] payload;
   } frame_rec_type;

   typedef struct packed {
      logic [Q_CNT_W-1:0] count;
      logic               full;
      logic               empty;
   } q_status_type;

   typedef struct packed {
      logic [31:0] low_limit;
      logic [31:0] high_limit;
      logic [31:0] fallback;
   } cfg_type;

endpackage

/* hdl/sfd_csr.sv */
// ---------------------------------------------------------------------------
// sfd_csr
// pressure limit and fallback registers behind the bus port
// ---------------------------------------------------------------------------
module sfd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sfd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output sfd_pkg::cfg_type              cfg
);
   import sfd_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_idx_type'(paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_LOW_LIMIT:  cfg_in.low_limit  = pwdata;
            REG_HIGH_LIMIT: cfg_in.high_limit = pwdata;
            REG_FALLBACK:   cfg_in.fallback   = pwdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_LOW_LIMIT:  prdata = cfg_ff.low_limit;
         REG_HIGH_LIMIT: prdata = cfg_ff.high_limit;
         REG_FALLBACK:   prdata = cfg_ff.fallback;
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_limit  <= PRESS_LOW_RESET;
         cfg_ff.high_limit <= PRESS_HIGH_RESET;
         cfg_ff.fallback   <= PRESS_FALL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/sfd_front.sv */
// ---------------------------------------------------------------------------
// sfd_front
// byte-level frame parser: sync hunt, header capture and payload store
// ---------------------------------------------------------------------------
module sfd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   input  sfd_pkg::q_status_type  q_status,
   output logic                   push,
   output sfd_pkg::frame_rec_type push_rec
);
   import sfd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_type_ff, held_type_in;
   logic [7:0] held_length_ff, held_length_in;
   logic [7:0] bytes_seen_ff, bytes_seen_in;
   logic [7:0] seen_next;
   logic [7:0] store_ff [KEPT_BYTES];
   logic [7:0] store_in [KEPT_BYTES];
   logic       accept;

   // only the checksum byte needs room in the queue
   assign req_stall = (phase_ff == PH_CSUM) && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign seen_next = bytes_seen_ff + 8'd1;

   always_comb begin
      phase_in       = phase_ff;
      held_type_in   = held_type_ff;
      held_length_in = held_length_ff;
      bytes_seen_in  = bytes_seen_ff;
      store_in       = store_ff;
      push           = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_SYNC2: begin
               phase_in = (req_rx_byte == SYNC_BYTE) ? PH_TYPE : PH_SYNC1;
            end
            PH_TYPE: begin
               held_type_in = req_rx_byte;
               phase_in     = PH_LEN;
            end
            PH_LEN: begin
               held_length_in = req_rx_byte;
               bytes_seen_in  = 8'd0;
               phase_in       = (req_rx_byte == 8'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA: begin
               if (bytes_seen_ff < 8'(KEPT_BYTES)) begin
                  store_in[bytes_seen_ff[BYTE_IDX_W-1:0]] = req_rx_byte;
               end
               bytes_seen_in = seen_next;
               if (seen_next >= held_length_ff) begin
                  phase_in = PH_CSUM;
               end
            end
            PH_CSUM: begin
               push     = 1'b1;
               phase_in = PH_SYNC1;
            end
            default: begin
               // first sync hunt, also recovers from a broken phase code
               phase_in = (req_rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
            end
         endcase
      end
   end

   always_comb begin
      push_rec.raw_type     = held_type_ff;
      push_rec.frame_length = held_length_ff;
      for (int i = 0; i < KEPT_BYTES; i++) begin
         push_rec.payload[i*8 +: 8] = store_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SYNC1;
         held_type_ff   <= 8'd0;
         held_length_ff <= 8'd0;
         bytes_seen_ff  <= 8'd0;
         for (int i = 0; i < KEPT_BYTES; i++) begin
            store_ff[i] <= 8'd0;
         end
      end else begin
         phase_ff       <= phase_in;
         held_type_ff   <= held_type_in;
         held_length_ff <= held_length_in;
         bytes_seen_ff  <= bytes_seen_in;
         store_ff       <= store_in;
      end
   end

endmodule

/* hdl/sfd_queue.sv */
// ---------------------------------------------------------------------------
// sfd_queue
// short frame record queue between the parser and the decoder
// ---------------------------------------------------------------------------
module sfd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sfd_pkg::frame_rec_type push_rec,
   input  logic                   pop,
   output sfd_pkg::frame_rec_type head_rec,
   output sfd_pkg::q_status_type  q_status
);
   import sfd_pkg::*;

   frame_rec_type      q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign q_status.count = count_ff;
   assign q_status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign q_status.empty = (count_ff == '0);

   assign do_push  = push && !q_status.full;
   assign do_pop   = pop && !q_status.empty;
   assign head_rec = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/sfd_back.sv */
// ---------------------------------------------------------------------------
// sfd_back
// frame decoder: field extraction, pressure limit check, result register
// ---------------------------------------------------------------------------
module sfd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sfd_pkg::frame_rec_type head_rec,
   input  sfd_pkg::q_status_type  q_status,
   input  sfd_pkg::cfg_type       cfg,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_frame_kind,
   output logic [7:0]             rsp_raw_type,
   output logic [7:0]             rsp_frame_length,
   output logic [31:0]            rsp_light_lux,
   output logic [15:0]            rsp_temperature_centi,
   output logic [15:0]            rsp_humidity_centi,
   output logic [31:0]            rsp_pressure_centi,
   output logic [15:0]            rsp_altitude_centi,
   output logic                   rsp_pressure_replaced
);
   import sfd_pkg::*;

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  type_ff, length_ff;
   logic [31:0] lux_ff, lux_in;
   logic [15:0] temp_ff, temp_in;
   logic [15:0] hum_ff, hum_in;
   logic [31:0] press_ff, press_in;
   logic [15:0] alt_ff, alt_in;
   logic        repl_ff, repl_in;
   logic [31:0] word0, press_raw;
   logic        out_of_range;

   // payload byte i sits at bits [8i +: 8], fields are big endian
   assign word0 = {head_rec.payload[7:0], head_rec.payload[15:8],
                   head_rec.payload[23:16], head_rec.payload[31:24]};
   assign press_raw = {head_rec.payload[39:32], head_rec.payload[47:40],
                       head_rec.payload[55:48], head_rec.payload[63:56]};
   assign out_of_range = (press_raw < cfg.low_limit) || (press_raw > cfg.high_limit);

   assign pop = !q_status.empty && (!valid_ff || !rsp_stall);

   always_comb begin
      kind_in  = KIND_UNKNOWN;
      lux_in   = 32'd0;
      temp_in  = 16'd0;
      hum_in   = 16'd0;
      press_in = 32'd0;
      alt_in   = 16'd0;
      repl_in  = 1'b0;
      if (head_rec.raw_type == TYPE_LIGHT) begin
         kind_in = KIND_LIGHT;
         lux_in  = word0;
      end else if (head_rec.raw_type == TYPE_ENV) begin
         kind_in  = KIND_ENV;
         temp_in  = word0[31:16];
         hum_in   = word0[15:0];
         press_in = out_of_range ? cfg.fallback : press_raw;
         alt_in   = {head_rec.payload[71:64], head_rec.payload[79:72]};
         repl_in  = out_of_range;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= kind_in;
         type_ff   <= head_rec.raw_type;
         length_ff <= head_rec.frame_length;
         lux_ff    <= lux_in;
         temp_ff   <= temp_in;
         hum_ff    <= hum_in;
         press_ff  <= press_in;
         alt_ff    <= alt_in;
         repl_ff   <= repl_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_frame_kind        = kind_ff;
   assign rsp_raw_type          = type_ff;
   assign rsp_frame_length      = length_ff;
   assign rsp_light_lux         = lux_ff;
   assign rsp_temperature_centi = temp_ff;
   assign rsp_humidity_centi    = hum_ff;
   assign rsp_pressure_centi    = press_ff;
   assign rsp_altitude_centi    = alt_ff;
   assign rsp_pressure_replaced = repl_ff;

endmodule

/* hdl/sensor_frame_deframer.sv */
// ---------------------------------------------------------------------------
// sensor_frame_deframer
// sync-hunting, length-prefixed frame parser for a serial sensor line
// ---------------------------------------------------------------------------
// channel  direction  handshake                  word
// req      in         req_valid / req_stall      rx_byte
// rsp      out        rsp_valid / rsp_stall      one decoded frame
// csr      in/out     psel penable pwrite pready 32-bit limit registers
//
// one byte a cycle is taken while req_stall is low; the parser updates its state in the same cycle.
// a decoded frame goes from its checksum byte through the frame queue into the result register onto rsp.
// req_stall rises only on a checksum byte while the two-entry frame queue is full.
// rsp_stall holds the result register; bytes keep flowing until a checksum byte meets a full queue.
// synchronous reset clears the parser, payload store, queue pointers and result valid, and loads the limit defaults.
// ---------------------------------------------------------------------------
module sensor_frame_deframer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_frame_kind,
   output logic [7:0]                    rsp_raw_type,
   output logic [7:0]                    rsp_frame_length,
   output logic [31:0]                   rsp_light_lux,
   output logic [15:0]                   rsp_temperature_centi,
   output logic [15:0]                   rsp_humidity_centi,
   output logic [31:0]                   rsp_pressure_centi,
   output logic [15:0]                   rsp_altitude_centi,
   output logic                          rsp_pressure_replaced,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sfd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import sfd_pkg::*;

   cfg_type       cfg;
   q_status_type  q_status;
   frame_rec_type push_rec, head_rec;
   logic          push, pop;

   sfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push        (push),
      .push_rec    (push_rec)
   );

   sfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_status (q_status)
   );

   sfd_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_rec              (head_rec),
      .q_status              (q_status),
      .cfg                   (cfg),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_frame_kind        (rsp_frame_kind),
      .rsp_raw_type          (rsp_raw_type),
      .rsp_frame_length      (rsp_frame_length),
      .rsp_light_lux         (rsp_light_lux),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_pressure_centi    (rsp_pressure_centi),
      .rsp_altitude_centi    (rsp_altitude_centi),
      .rsp_pressure_replaced (rsp_pressure_replaced)
   );

`include "sensor_frame_deframer_macros.svh"

   // a finished frame is never dropped at the queue
   `SFD_ASSERT_NOW(a_no_push_when_full, push, !q_status.full, "frame pushed into full queue")

   // a pushed frame is held somewhere downstream on the next cycle
   `SFD_ASSERT_NEXT(a_push_lands, push, (q_status.count != '0) || rsp_valid, "pushed frame lost")

   // the replacement flag belongs to environment frames only
   `SFD_ASSERT_NOW(a_repl_env_only, rsp_valid && rsp_pressure_replaced, rsp_frame_kind == KIND_ENV, "replace flag on non-environment frame")

   // no result appears without a queued frame behind it
   `SFD_ASSERT_NEXT(a_no_phantom, rsp_valid && !rsp_stall && q_status.empty, !rsp_valid, "result without queued frame")

endmodule

/* tb/sensor_frame_deframer_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sensor_frame_deframer_test
// drives received bytes into the deframer, predicts every decoded frame from
// its own parser copy and checks each result field; pressure limits are
// reprogrammed between phases while both sides idle and stall at random
// ---------------------------------------------------------------------------
module sensor_frame_deframer_test;
   import sfd_pkg::*;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      frame_kind_type kind;
      logic [7:0]     raw_type;
      logic [7:0]     frame_length;
      logic [31:0]    light_lux;
      logic [15:0]    temperature_centi;
      logic [15:0]    humidity_centi;
      logic [31:0]    pressure_centi;
      logic [15:0]    altitude_centi;
      logic           pressure_replaced;
   } frame_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_frame_kind;
   logic [7:0]            rsp_raw_type;
   logic [7:0]            rsp_frame_length;
   logic [31:0]           rsp_light_lux;
   logic [15:0]           rsp_temperature_centi;
   logic [15:0]           rsp_humidity_centi;
   logic [31:0]           rsp_pressure_centi;
   logic [15:0]           rsp_altitude_centi;
   logic                  rsp_pressure_replaced;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   sensor_frame_deframer dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_frame_kind        (rsp_frame_kind),
      .rsp_raw_type          (rsp_raw_type),
      .rsp_frame_length      (rsp_frame_length),
      .rsp_light_lux         (rsp_light_lux),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_pressure_centi    (rsp_pressure_centi),
      .rsp_altitude_centi    (rsp_altitude_centi),
      .rsp_pressure_replaced (rsp_pressure_replaced),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   // parser copy and limit registers as the block should hold them
   phase_type     parse_phase;
   logic [7:0]    held_type;
   logic [7:0]    held_length;
   logic [7:0]    bytes_seen;
   logic [7:0]    payload_copy [KEPT_BYTES];
   logic [31:0]   lim_low;
   logic [31:0]   lim_high;
   logic [31:0]   lim_fallback;

   frame_result_type pending_frames[$];

   int mismatch_count;
   int frames_checked;
   int light_seen;
   int env_seen;
   int unknown_seen;
   int replaced_seen;
   int bytes_sent;
   int frame_bytes;
   int hold_left;
   int stall_burst;
   bit sender_idle_on;
   bit receiver_idle_on;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #5ms;
      $display("timeout with %0d frames still pending", pending_frames.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_failure(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) report_failure(what, want, got);
   endtask

   // ---- frame predictor ----

   task automatic decode_byte(input logic [7:0] b);
      frame_result_type res;
      logic [31:0]      press;
      logic             bad;
      case (parse_phase)
         PH_SYNC2: parse_phase = (b == SYNC_BYTE) ? PH_TYPE : PH_SYNC1;
         PH_TYPE: begin
            held_type   = b;
            parse_phase = PH_LEN;
         end
         PH_LEN: begin
            held_length = b;
            bytes_seen  = 8'd0;
            parse_phase = (b == 8'd0) ? PH_CSUM : PH_DATA;
         end
         PH_DATA: begin
            if (bytes_seen < KEPT_BYTES) payload_copy[bytes_seen[BYTE_IDX_W-1:0]] = b;
            bytes_seen = bytes_seen + 8'd1;
            if (bytes_seen >= held_length) parse_phase = PH_CSUM;
         end
         PH_CSUM: begin
            // checksum byte is swallowed without a check and closes the frame
            parse_phase      = PH_SYNC1;
            res              = '0;
            res.raw_type     = held_type;
            res.frame_length = held_length;
            if (held_type == TYPE_LIGHT) begin
               res.kind      = KIND_LIGHT;
               res.light_lux = {payload_copy[0], payload_copy[1],
                                payload_copy[2], payload_copy[3]};
            end else if (held_type == TYPE_ENV) begin
               press = {payload_copy[4], payload_copy[5], payload_copy[6], payload_copy[7]};
               bad   = (press < lim_low) || (press > lim_high);
               res.kind              = KIND_ENV;
               res.temperature_centi = {payload_copy[0], payload_copy[1]};
               res.humidity_centi    = {payload_copy[2], payload_copy[3]};
               res.pressure_centi    = bad ? lim_fallback : press;
               res.altitude_centi    = {payload_copy[8], payload_copy[9]};
               res.pressure_replaced = bad;
            end else begin
               res.kind = KIND_UNKNOWN;
            end
            pending_frames.push_back(res);
         end
         default: parse_phase = (b == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
      endcase
   endtask

   // ---- result checker ----

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            report_failure("result with no frame pending", 32'd0, 32'(rsp_raw_type));
         end else begin
            want = pending_frames.pop_front();
            frames_checked++;
            case (want.kind)
               KIND_LIGHT: light_seen++;
               KIND_ENV:   env_seen++;
               default:    unknown_seen++;
            endcase
            if (want.pressure_replaced) replaced_seen++;
            check_field("frame_kind", 32'(want.kind), 32'(rsp_frame_kind));
            check_field("raw_type", 32'(want.raw_type), 32'(rsp_raw_type));
            check_field("frame_length", 32'(want.frame_length), 32'(rsp_frame_length));
            check_field("light_lux", want.light_lux, rsp_light_lux);
            check_field("temperature_centi", 32'(want.temperature_centi),
                        32'(rsp_temperature_centi));
            check_field("humidity_centi", 32'(want.humidity_centi),
                        32'(rsp_humidity_centi));
            check_field("pressure_centi", want.pressure_centi, rsp_pressure_centi);
            check_field("altitude_centi", 32'(want.altitude_centi),
                        32'(rsp_altitude_centi));
            check_field("pressure_replaced", 32'(want.pressure_replaced),
                        32'(rsp_pressure_replaced));
         end
      end
   end

   // ---- receiver stall: long hold-off first, then random bursts ----

   always @(negedge clock) begin
      logic stall_next;
      stall_next = 1'b0;
      if (reset) begin
         stall_burst = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else if (stall_burst > 0) begin
         stall_burst--;
         stall_next = 1'b1;
      end else if (receiver_idle_on && $urandom_range(0, 11) == 0) begin
         stall_burst = $urandom_range(1, 14) - 1;
         stall_next  = 1'b1;
      end
      rsp_stall <= stall_next;
   end

   // ---- byte sender ----

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (sender_idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 14);
         repeat (gap) begin
            @(negedge clock);
            req_valid   <= 1'b0;
            req_rx_byte <= 8'($urandom);
         end
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flen,
                             input byte_q_type body);
      send_byte(SYNC_BYTE);
      send_byte(SYNC_BYTE);
      send_byte(ftype);
      send_byte(flen);
      for (int k = 0; k < flen; k++)
         send_byte((k < body.size()) ? body[k] : 8'($urandom));
      send_byte(8'($urandom));
      frame_bytes += 5 + flen;
   endtask

   function automatic byte_q_type env_body(input logic [31:0] press);
      byte_q_type q;
      repeat (4) q.push_back(8'($urandom));
      q.push_back(press[31:24]);
      q.push_back(press[23:16]);
      q.push_back(press[15:8]);
      q.push_back(press[7:0]);
      repeat (2) q.push_back(8'($urandom));
      return q;
   endfunction

   // any byte but the sync value, so the parser stays in the hunt
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 254));
      if (b >= SYNC_BYTE) b = b + 8'd1;
      return b;
   endfunction

   function automatic logic [31:0] pick_pressure();
      case ($urandom_range(0, 5))
         0: return lim_low - 32'd1;
         1: return lim_low;
         2: return lim_high;
         3: return lim_high + 32'd1;
         4: return $urandom;
         default: return $urandom_range(lim_low, lim_high);
      endcase
   endfunction

   task automatic send_random_frame();
      byte_q_type body;
      logic [7:0] ftype;
      logic [7:0] flen;
      int         pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         repeat ($urandom_range(1, 4)) send_byte(noise_byte());
      end else if (pick == 1) begin
         // broken sync pair
         send_byte(SYNC_BYTE);
         send_byte(noise_byte());
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         ftype = TYPE_LIGHT;
         flen  = 8'd4;
      end else if (pick < 8) begin
         ftype = TYPE_ENV;
         flen  = 8'd10;
         body  = env_body(pick_pressure());
      end else begin
         ftype = 8'($urandom);
         flen  = 8'($urandom_range(0, 12));
      end
      pick = $urandom_range(0, 29);
      if (pick < 6) flen = 8'($urandom_range(0, 12));
      else if (pick == 6) flen = 8'($urandom_range(13, 255));
      send_frame(ftype, flen, body);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      // let the frame queue and result register settle
      repeat (8) @(posedge clock);
   endtask

   // ---- register port ----

   task automatic csr_access(input logic is_write, input reg_idx_type idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_write(input reg_idx_type idx, input logic [31:0] value);
      logic [31:0] rdata;
      csr_access(1'b1, idx, value, rdata);
      case (idx)
         REG_LOW_LIMIT:  lim_low      = value;
         REG_HIGH_LIMIT: lim_high     = value;
         default:        lim_fallback = value;
      endcase
      csr_access(1'b0, idx, 32'd0, rdata);
      check_field("register readback", value, rdata);
   endtask

   task automatic program_limits(input logic [31:0] low, input logic [31:0] high,
                                 input logic [31:0] fallback);
      wait_until_drained();
      csr_write(REG_LOW_LIMIT, low);
      csr_write(REG_HIGH_LIMIT, high);
      csr_write(REG_FALLBACK, fallback);
   endtask

   // ---- tests ----

   task automatic test_directed_frames();
      byte_q_type body;
      // second sync byte wrong, then hunting restarts
      send_byte(SYNC_BYTE);
      send_byte(8'h00);
      body = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_frame(TYPE_LIGHT, 8'd4, body);
      body = {8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h86, 8'hA0, 8'hFF, 8'hFF};
      send_frame(TYPE_ENV, 8'd10, body);
      // unknown type with zero length: checksum follows the length byte
      body = {};
      send_frame(8'hA7, 8'd0, body);
      wait_until_drained();
   endtask

   task automatic test_limit_extremes();
      logic [31:0] settings [4][3];
      settings = '{'{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                   '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0},
                   '{32'd5, 32'd4, 32'd12345},
                   '{PRESS_LOW_RESET, PRESS_HIGH_RESET, PRESS_FALL_RESET}};
      foreach (settings[s]) begin
         program_limits(settings[s][0], settings[s][1], settings[s][2]);
         send_frame(TYPE_ENV, 8'd10, env_body(lim_low - 32'd1));
         send_frame(TYPE_ENV, 8'd10, env_body(lim_low));
         send_frame(TYPE_ENV, 8'd10, env_body(lim_high));
         send_frame(TYPE_ENV, 8'd10, env_body(lim_high + 32'd1));
         send_frame(TYPE_ENV, 8'd10, env_body(32'hFFFF_FFFF));
      end
      wait_until_drained();
   endtask

   task automatic test_backpressure();
      byte_q_type body;
      sender_idle_on = 1'b0;
      hold_left      = 250;
      // short frames back to back fill the frame queue behind the held result
      repeat (10) send_frame(TYPE_LIGHT, 8'd4, body);
      wait_until_drained();
      sender_idle_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      repeat (6) send_random_frame();
      wait_until_drained();
      repeat (6) send_random_frame();
      wait_until_drained();
   endtask

   task automatic test_random_traffic();
      int stop_at;
      for (int ph = 0; ph < 4; ph++) begin
         program_limits($urandom_range(70000, 100000), $urandom_range(100000, 130000),
                        $urandom);
         if (ph == 3) begin
            // closing stretch runs at full rate
            sender_idle_on   = 1'b0;
            receiver_idle_on = 1'b0;
         end
         stop_at = frame_bytes + 150;
         while (frame_bytes < stop_at) send_random_frame();
      end
      wait_until_drained();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_rx_byte    = 8'd0;
      rsp_stall      = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = 32'd0;
      parse_phase    = PH_SYNC1;
      held_type      = 8'd0;
      held_length    = 8'd0;
      bytes_seen     = 8'd0;
      foreach (payload_copy[i]) payload_copy[i] = 8'd0;
      lim_low        = PRESS_LOW_RESET;
      lim_high       = PRESS_HIGH_RESET;
      lim_fallback   = PRESS_FALL_RESET;
      mismatch_count = 0;
      frames_checked = 0;
      light_seen     = 0;
      env_seen       = 0;
      unknown_seen   = 0;
      replaced_seen  = 0;
      bytes_sent     = 0;
      frame_bytes    = 0;
      hold_left      = 0;
      stall_burst    = 0;
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_limit_extremes();
      test_backpressure();
      test_sender_pause();
      test_random_traffic();

      $display("sent %0d bytes, checked %0d frames: %0d light, %0d environment, %0d unknown",
               bytes_sent, frames_checked, light_seen, env_seen, unknown_seen);
      $display("%0d pressures replaced by the fallback, %0d failures", replaced_seen,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
